[hdl/mi3_pkg.sv]
// Shared widths, types and codes for the 3x3 matrix inverse pipeline.
package mi3_pkg;

    // Element format.
    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Product, cofactor, partial product and determinant widths.
    localparam int PRODW = 2 * ELEM_WIDTH;
    localparam int CW    = 2 * ELEM_WIDTH + 1;
    localparam int PARTW = 2 * ELEM_WIDTH + 1;
    localparam int DW    = 3 * ELEM_WIDTH + 3;

    // Dividend width for the rounded quotient and partial remainder width.
    localparam int NUMW = 2 * ELEM_WIDTH + 2 * FRAC_BITS + 2;
    localparam int TW   = ((NUMW > DW) ? NUMW : DW) + 1;
    localparam int PW   = DW + 1;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef logic signed [PRODW-1:0]      prod_t;
    typedef logic signed [CW-1:0]         cof_t;
    typedef logic        [CW-1:0]         cmag_t;
    typedef logic signed [PARTW-1:0]      part_t;
    typedef logic signed [DW-1:0]         det_t;
    typedef logic        [DW-1:0]         mag_t;
    typedef logic        [DW:0]           rnd_t;
    typedef logic        [TW-1:0]         t_t;
    typedef logic        [PW-1:0]         d2_t;
    typedef logic        [ELEM_WIDTH-1:0] q_t;

    // Saturation limits as magnitudes.
    localparam q_t LIM    = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
    localparam q_t LIM_M1 = {1'b0, {(ELEM_WIDTH-1){1'b1}}};

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SINGULAR = 2'd1,
        STATUS_SAT      = 2'd2
    } status_t;

    // Result of one divider lane.
    typedef struct packed {
        logic high;
        logic neg;
        q_t   q;
    } lane_res_t;

endpackage

[hdl/mi3_div_lane.sv]
// Pipelined restoring divider lane: one quotient bit per stage.
module mi3_div_lane (
    input  logic               clk,
    input  logic               en,
    input  mi3_pkg::t_t        t,
    input  mi3_pkg::d2_t       d2,
    input  logic               neg,
    output mi3_pkg::lane_res_t res
);
    import mi3_pkg::*;

    localparam int W = ELEM_WIDTH;

    d2_t  p_reg    [0:W];
    q_t   low_reg  [0:W];
    q_t   q_reg    [0:W];
    d2_t  d2_reg   [0:W];
    logic high_reg [0:W];
    logic neg_reg  [0:W];

    // Entry stage: split the dividend and flag a quotient that needs more bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]    <= PW'(t >> W);
            low_reg[0]  <= t[W-1:0];
            q_reg[0]    <= '0;
            d2_reg[0]   <= d2;
            high_reg[0] <= (PW'(t >> W) >= d2);
            neg_reg[0]  <= neg;
        end
    end

    // One compare and subtract per stage, shifting in the next dividend bit.
    for (genvar j = 1; j <= W; j++)
    begin : g_step
        logic [PW:0] sh;
        logic [PW:0] diff;
        logic        ge;

        assign sh   = {p_reg[j-1], low_reg[j-1][W-1]};
        assign diff = sh - {1'b0, d2_reg[j-1]};
        assign ge   = (sh >= {1'b0, d2_reg[j-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[j]    <= ge ? diff[PW-1:0] : sh[PW-1:0];
                low_reg[j]  <= {low_reg[j-1][W-2:0], 1'b0};
                q_reg[j]    <= {q_reg[j-1][W-2:0], ge};
                d2_reg[j]   <= d2_reg[j-1];
                high_reg[j] <= high_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
            end
        end
    end

    assign res.high = high_reg[W];
    assign res.neg  = neg_reg[W];
    assign res.q    = q_reg[W];

endmodule

[hdl/matrix_inverse_3x3.sv]
// Top level of the 3x3 matrix inverse: cofactors, determinant, division, saturation.
//
// One matrix of nine signed Q16.16 elements enters per transfer on the input
// channel (in_valid / in_stall); one result leaves per transfer on the output
// channel (out_valid / out_stall): the nine inverse elements, the determinant
// and a status code (ok, singular, saturated).
// Throughput is one matrix per cycle while the output is not stalled. The pipeline
// has seven stages of products, cofactors, determinant and rounding setup,
// ELEM_WIDTH + 1 stages of the restoring divider lanes (one quotient bit per
// stage), and the output register.
// A singular matrix returns zero elements with status singular; any value
// that overflows the element format saturates and sets status saturated.
// Reset clears all valid bits; no other state is kept between matrices.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
module matrix_inverse_3x3 (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  mi3_pkg::elem_t   a00,
    input  mi3_pkg::elem_t   a01,
    input  mi3_pkg::elem_t   a02,
    input  mi3_pkg::elem_t   a10,
    input  mi3_pkg::elem_t   a11,
    input  mi3_pkg::elem_t   a12,
    input  mi3_pkg::elem_t   a20,
    input  mi3_pkg::elem_t   a21,
    input  mi3_pkg::elem_t   a22,
    output logic             out_valid,
    input  logic             out_stall,
    output mi3_pkg::elem_t   b00,
    output mi3_pkg::elem_t   b01,
    output mi3_pkg::elem_t   b02,
    output mi3_pkg::elem_t   b10,
    output mi3_pkg::elem_t   b11,
    output mi3_pkg::elem_t   b12,
    output mi3_pkg::elem_t   b20,
    output mi3_pkg::elem_t   b21,
    output mi3_pkg::elem_t   b22,
    output mi3_pkg::elem_t   det_value,
    output mi3_pkg::status_t status
);
    import mi3_pkg::*;

    localparam int W = ELEM_WIDTH;

    // Cofactor k is m[P]*m[Q] - m[R]*m[S].
    localparam int IDX_P [9] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
    localparam int IDX_Q [9] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
    localparam int IDX_R [9] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
    localparam int IDX_S [9] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

    localparam rnd_t RND_HALF = rnd_t'(1) << (2 * FRAC_BITS - 1);

    typedef struct packed {
        logic  zero;
        logic  det_sat;
        elem_t det_val;
    } side_t;

    logic       en;
    elem_t      m_in [9];

    logic [7:1] vld_reg;
    logic       vs_reg [0:W];
    logic       out_valid_reg;

    prod_t      pa_reg [9];
    prod_t      pb_reg [9];
    elem_t      mc1_reg [3];
    cof_t       cof2_reg [9];
    elem_t      mc2_reg [3];
    cof_t       cof3_reg [9];
    part_t      pl_reg [3];
    part_t      ph_reg [3];
    cof_t       cof4_reg [9];
    det_t       term_reg [3];
    cof_t       cof5_reg [9];
    det_t       det5_reg;
    cmag_t      cmag6_reg [9];
    logic       cneg6_reg [9];
    mag_t       dmag6_reg;
    logic       dneg6_reg;
    logic       zero6_reg;
    t_t         t7_reg [9];
    d2_t        d27_reg;
    logic       neg7_reg [9];
    side_t      side_reg [0:W+1];

    rnd_t       dr;
    rnd_t       dq;
    logic       det_sat_next;
    q_t         det_mag;

    lane_res_t  lane_res [9];
    logic       lane_sat [9];
    q_t         lane_mag [9];
    elem_t      lane_val [9];
    logic       any_sat;

    elem_t      out_b_reg [9];
    elem_t      det_out_reg;
    status_t    status_reg;

    // The whole pipeline advances unless a finished result is held back.
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    assign m_in[0] = a00;
    assign m_in[1] = a01;
    assign m_in[2] = a02;
    assign m_in[3] = a10;
    assign m_in[4] = a11;
    assign m_in[5] = a12;
    assign m_in[6] = a20;
    assign m_in[7] = a21;
    assign m_in[8] = a22;

    // Valid bits travel with the data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j <= W; j++)
            begin
                vs_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg   <= {vld_reg[6:1], in_valid};
            vs_reg[0] <= vld_reg[7];
            for (int j = 1; j <= W; j++)
            begin
                vs_reg[j] <= vs_reg[j-1];
            end
            out_valid_reg <= vs_reg[W];
        end
    end

    // Stages one to six: products, cofactors, determinant and magnitudes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                pa_reg[k]   <= m_in[IDX_P[k]] * m_in[IDX_Q[k]];
                pb_reg[k]   <= m_in[IDX_R[k]] * m_in[IDX_S[k]];
                cof2_reg[k] <= cof_t'(pa_reg[k]) - cof_t'(pb_reg[k]);
                cof3_reg[k] <= cof2_reg[k];
                cof4_reg[k] <= cof3_reg[k];
                cof5_reg[k] <= cof4_reg[k];
                cmag6_reg[k] <= cof5_reg[k][CW-1] ? cmag_t'(-cof5_reg[k])
                                                  : cmag_t'(cof5_reg[k]);
                cneg6_reg[k] <= cof5_reg[k][CW-1];
            end
            mc1_reg[0] <= a00;
            mc1_reg[1] <= a10;
            mc1_reg[2] <= a20;
            for (int i = 0; i < 3; i++)
            begin
                mc2_reg[i]  <= mc1_reg[i];
                // Split the wide cofactor so each multiplier stays near 32 bits.
                pl_reg[i]   <= part_t'(mc2_reg[i])
                             * part_t'($signed({1'b0, cof2_reg[3*i][W-1:0]}));
                ph_reg[i]   <= part_t'(mc2_reg[i])
                             * part_t'($signed(cof2_reg[3*i][CW-1:W]));
                term_reg[i] <= (det_t'(ph_reg[i]) <<< W) + det_t'(pl_reg[i]);
            end
            det5_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            dmag6_reg <= det5_reg[DW-1] ? mag_t'(-det5_reg) : mag_t'(det5_reg);
            dneg6_reg <= det5_reg[DW-1];
            zero6_reg <= (det5_reg == '0);
        end
    end

    // Determinant rounded to the element format, ties away from zero, and saturated.
    always_comb
    begin
        dr           = rnd_t'(dmag6_reg) + RND_HALF;
        dq           = dr >> (2 * FRAC_BITS);
        det_sat_next = dneg6_reg ? (dq > rnd_t'(LIM)) : (dq > rnd_t'(LIM_M1));
        if (det_sat_next)
        begin
            det_mag = dneg6_reg ? LIM : LIM_M1;
        end
        else
        begin
            det_mag = dq[W-1:0];
        end
    end

    // Stage seven: dividends and doubled divisor for the lanes, then side data
    // delayed to line up with the lane outputs.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                t7_reg[k]   <= (t_t'(cmag6_reg[k]) << (2 * FRAC_BITS + 1))
                             + t_t'(dmag6_reg);
                neg7_reg[k] <= cneg6_reg[k] ^ dneg6_reg;
            end
            d27_reg <= {dmag6_reg, 1'b0};
            side_reg[0].zero    <= zero6_reg;
            side_reg[0].det_sat <= det_sat_next;
            side_reg[0].det_val <= $signed(dneg6_reg ? (q_t'(0) - det_mag) : det_mag);
            for (int j = 1; j <= W + 1; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // Inverse element b[r][c] comes from cofactor c*3+r.
    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        mi3_div_lane u_lane (
            .clk (clk),
            .en  (en),
            .t   (t7_reg[(k % 3) * 3 + (k / 3)]),
            .d2  (d27_reg),
            .neg (neg7_reg[(k % 3) * 3 + (k / 3)]),
            .res (lane_res[k])
        );
    end

    // Sign and saturation of each quotient.
    always_comb
    begin
        any_sat = side_reg[W+1].det_sat;
        for (int k = 0; k < 9; k++)
        begin
            lane_sat[k] = lane_res[k].high
                        || (lane_res[k].neg ? (lane_res[k].q > LIM) : lane_res[k].q[W-1]);
            if (lane_sat[k])
            begin
                lane_mag[k] = lane_res[k].neg ? LIM : LIM_M1;
            end
            else
            begin
                lane_mag[k] = lane_res[k].q;
            end
            lane_val[k] = $signed(lane_res[k].neg ? (q_t'(0) - lane_mag[k]) : lane_mag[k]);
            any_sat     = any_sat | lane_sat[k];
        end
    end

    // Output register; a singular matrix gives zero fields.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                out_b_reg[k] <= side_reg[W+1].zero ? elem_t'(0) : lane_val[k];
            end
            det_out_reg <= side_reg[W+1].zero ? elem_t'(0) : side_reg[W+1].det_val;
            if (side_reg[W+1].zero)
            begin
                status_reg <= STATUS_SINGULAR;
            end
            else if (any_sat)
            begin
                status_reg <= STATUS_SAT;
            end
            else
            begin
                status_reg <= STATUS_OK;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign b00       = out_b_reg[0];
    assign b01       = out_b_reg[1];
    assign b02       = out_b_reg[2];
    assign b10       = out_b_reg[3];
    assign b11       = out_b_reg[4];
    assign b12       = out_b_reg[5];
    assign b20       = out_b_reg[6];
    assign b21       = out_b_reg[7];
    assign b22       = out_b_reg[8];
    assign det_value = det_out_reg;
    assign status    = status_reg;

endmodule

[hdl/mi3_checker.sv]
// Port-level checker for the 3x3 matrix inverse and its bind statement.
module mi3_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input mi3_pkg::elem_t   b00,
    input mi3_pkg::elem_t   b11,
    input mi3_pkg::elem_t   b22,
    input mi3_pkg::elem_t   det_value,
    input mi3_pkg::status_t status
);
    import mi3_pkg::*;

    // A stalled result stays on the output.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped while stalled");

    // With no result waiting, the input side is never stalled.
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // A held result freezes the pipeline, so the input is stalled too.
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while output held");

    // A singular matrix returns a zero determinant and zero diagonal fields.
    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_SINGULAR
            |-> det_value == 0 && b00 == 0 && b11 == 0 && b22 == 0)
        else $error("singular result with nonzero fields");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .b00       (b00),
    .b11       (b11),
    .b22       (b22),
    .det_value (det_value),
    .status    (status)
);
